>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fit placement allocator
// Placement modes, register indexes, controller states and the status flags
// that travel with the scan beat along the row of block cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

	// Placement policy, as written to the mode register.
	typedef enum logic [1:0] {
		MODE_FIRST = 2'd0,
		MODE_NEXT  = 2'd1,
		MODE_BEST  = 2'd2,
		MODE_WORST = 2'd3
	} mode_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	// Configuration register indexes.
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Input action codes.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PLACE = 1'b1;

	localparam int SUM_W   = 20;
	localparam int LEFT_W  = 16;
	localparam int AMT_W   = 16;
	localparam int BIDX_W  = 4;
	localparam int COUNT_W = 5;

	// Status that moves with the scan beat from cell to cell.
	typedef struct packed {
		logic valid;
		logic found_a;
		logic found_b;
	} flags_t;

endpackage

`default_nettype wire

>>> rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one block of the placement table
// Holds the free capacity of one block. When the scan beat passes, the cell
// stores a load aimed at it, adds its capacity to the running sum if it is in
// use and updates the candidate picks, then registers the beat for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell #(
	parameter int CELL_INDEX = 0,
	parameter int SIZE_BITS  = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// item held by the controller for the whole scan
	input  wire logic                       cmd_place,
	input  wire fpa_pkg::mode_t             cmd_mode,
	input  wire logic [SIZE_BITS-1:0]       cmd_req,
	input  wire logic                       cmd_load_ok,
	input  wire logic [IDX_W-1:0]           cmd_load_idx,
	input  wire logic [CNT_W-1:0]           cmd_count,
	input  wire logic [IDX_W-1:0]           cmd_start,
	// capacity reduction of the chosen block
	input  wire logic                       commit_valid,
	input  wire logic [IDX_W-1:0]           commit_pick,
	// scan beat from the previous cell
	input  wire fpa_pkg::flags_t            in_flags,
	input  wire logic [fpa_pkg::SUM_W-1:0]  in_sum,
	input  wire logic [IDX_W-1:0]           in_pick_a,
	input  wire logic [SIZE_BITS-1:0]       in_val_a,
	input  wire logic [IDX_W-1:0]           in_pick_b,
	input  wire logic [SIZE_BITS-1:0]       in_val_b,
	// scan beat to the next cell
	output fpa_pkg::flags_t                 out_flags,
	output logic [fpa_pkg::SUM_W-1:0]       out_sum,
	output logic [IDX_W-1:0]                out_pick_a,
	output logic [SIZE_BITS-1:0]            out_val_a,
	output logic [IDX_W-1:0]                out_pick_b,
	output logic [SIZE_BITS-1:0]            out_val_b
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

	logic [SIZE_BITS-1:0]       val_q;
	logic                       load_hit;
	logic [SIZE_BITS-1:0]       cur_val;
	logic                       in_use;
	logic                       fits;
	fpa_pkg::flags_t            nx_flags;
	logic [fpa_pkg::SUM_W-1:0]  nx_sum;
	logic [IDX_W-1:0]           nx_pick_a;
	logic [SIZE_BITS-1:0]       nx_val_a;
	logic [IDX_W-1:0]           nx_pick_b;
	logic [SIZE_BITS-1:0]       nx_val_b;

	fpa_pkg::flags_t            flags_q;
	logic [fpa_pkg::SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]           pick_a_q;
	logic [SIZE_BITS-1:0]       val_a_q;
	logic [IDX_W-1:0]           pick_b_q;
	logic [SIZE_BITS-1:0]       val_b_q;

	always_comb begin
		load_hit  = !cmd_place && cmd_load_ok && (cmd_load_idx == MY_IDX);
		cur_val   = load_hit ? cmd_req : val_q;
		in_use    = MY_CNT < cmd_count;
		fits      = cmd_place && in_use && (cur_val >= cmd_req);
		nx_flags  = in_flags;
		nx_sum    = in_sum + (in_use ? fpa_pkg::SUM_W'(cur_val) : '0);
		nx_pick_a = in_pick_a;
		nx_val_a  = in_val_a;
		nx_pick_b = in_pick_b;
		nx_val_b  = in_val_b;
		if (fits) begin
			unique case (cmd_mode)
				fpa_pkg::MODE_FIRST: begin
					if (!in_flags.found_a) begin
						nx_flags.found_a = 1'b1;
						nx_pick_a        = MY_IDX;
						nx_val_a         = cur_val;
					end
				end
				fpa_pkg::MODE_NEXT: begin
					// Candidate a covers the blocks from the start point up,
					// candidate b the wrapped part below it.
					if (MY_IDX >= cmd_start) begin
						if (!in_flags.found_a) begin
							nx_flags.found_a = 1'b1;
							nx_pick_a        = MY_IDX;
							nx_val_a         = cur_val;
						end
					end else if (!in_flags.found_b) begin
						nx_flags.found_b = 1'b1;
						nx_pick_b        = MY_IDX;
						nx_val_b         = cur_val;
					end
				end
				fpa_pkg::MODE_BEST: begin
					if (!in_flags.found_a || (cur_val < in_val_a)) begin
						nx_flags.found_a = 1'b1;
						nx_pick_a        = MY_IDX;
						nx_val_a         = cur_val;
					end
				end
				fpa_pkg::MODE_WORST: begin
					if (!in_flags.found_a || (cur_val > in_val_a)) begin
						nx_flags.found_a = 1'b1;
						nx_pick_a        = MY_IDX;
						nx_val_a         = cur_val;
					end
				end
				default: begin
					nx_flags = in_flags;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q   <= '0;
			flags_q <= '0;
		end else begin
			flags_q <= nx_flags;
			if (in_flags.valid && load_hit) begin
				val_q <= cmd_req;
			end else if (commit_valid && (commit_pick == MY_IDX)) begin
				val_q <= val_q - cmd_req;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_flags.valid) begin
			sum_q    <= nx_sum;
			pick_a_q <= nx_pick_a;
			val_a_q  <= nx_val_a;
			pick_b_q <= nx_pick_b;
			val_b_q  <= nx_val_b;
		end
	end

	assign out_flags  = flags_q;
	assign out_sum    = sum_q;
	assign out_pick_a = pick_a_q;
	assign out_val_a  = val_a_q;
	assign out_pick_b = pick_b_q;
	assign out_val_b  = val_b_q;

endmodule

`default_nettype wire

>>> rtl/fit_placement_allocator.sv
// ----------------------------------------------------------------------------
// fit_placement_allocator: first, next, best and worst fit block placement
// Usage:
// The slave stream takes one beat per item: s_tuser is the action (load a
// block capacity or place a request), s_tdata the block index and amount.
// The master stream returns one beat per item: m_tuser says whether a
// request was placed, m_tdata the block, its remaining capacity and the
// free total over the blocks in use.
// Each item sends one scan beat down the row of NUM_BLOCKS cells, one cell
// per cycle. One item is in work at a time; the next is accepted in the
// cycle after the result is latched. A placed request reduces the chosen
// cell in the cycle after the result is latched.
// If the receiver stalls, the result waits in the output register; the next
// item is still taken and its scan runs, but its result waits for that
// register to drain.
// Reset clears all capacities and the next fit cursor, and sets first fit
// and a block count of sixteen. The user must write mode and count through
// the cfg port only while no item is in work; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_placement_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // block_index[3:0], amount[19:4], zero pad
	input  wire logic [0:0]  s_tuser,   // action[0]
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // chosen_block[3:0], block_left[19:4],
	                                    // free_total[39:20]
	output logic [0:0]       m_tuser    // placed[0]
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	// configuration
	fpa_pkg::mode_t                mode_q;
	logic [fpa_pkg::COUNT_W-1:0]   count_q;
	logic [CNT_W-1:0]              count_use;

	// item held during the scan
	logic                          place_q;
	logic [SIZE_BITS-1:0]          req_q;
	logic                          load_ok_q;
	logic [IDX_W-1:0]              load_idx_q;
	logic [fpa_pkg::BIDX_W-1:0]    bidx_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [IDX_W-1:0]              start_q;
	logic                          launch_q;
	logic [IDX_W-1:0]              cursor_q;

	// commit of the chosen block
	logic                          commit_q;
	logic [IDX_W-1:0]              commit_pick_q;

	// output register
	logic                          m_valid_q;
	logic [39:0]                   m_data_q;
	logic                          m_placed_q;

	fpa_pkg::state_t               state_q, state_d;
	logic                          accept;
	logic                          finish;

	// chain of scan beats, entry 0 from the controller
	fpa_pkg::flags_t               ch_flags  [NUM_BLOCKS+1];
	logic [fpa_pkg::SUM_W-1:0]     ch_sum    [NUM_BLOCKS+1];
	logic [IDX_W-1:0]              ch_pick_a [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0]          ch_val_a  [NUM_BLOCKS+1];
	logic [IDX_W-1:0]              ch_pick_b [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0]          ch_val_b  [NUM_BLOCKS+1];

	// result of the scan
	fpa_pkg::flags_t               lf;
	logic                          res_placed;
	logic [IDX_W-1:0]              res_pick;
	logic [SIZE_BITS-1:0]          res_pval;
	logic [SIZE_BITS-1:0]          res_rest;
	logic [fpa_pkg::LEFT_W-1:0]    res_left;
	logic [fpa_pkg::BIDX_W-1:0]    res_block;
	logic [fpa_pkg::SUM_W-1:0]     res_sum;

	always_comb begin
		if (count_q == '0) begin
			count_use = CNT_W'(1);
		end else if (32'(count_q) > NUM_BLOCKS) begin
			count_use = CNT_W'(NUM_BLOCKS);
		end else begin
			count_use = CNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fpa_pkg::MODE_FIRST;
			count_q <= fpa_pkg::COUNT_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpa_pkg::REG_MODE:  mode_q  <= fpa_pkg::mode_t'(cfg_data[1:0]);
				fpa_pkg::REG_COUNT: count_q <= cfg_data;
				default:            mode_q  <= mode_q;
			endcase
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			fpa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				accept   = s_tvalid;
				if (s_tvalid) begin
					state_d = fpa_pkg::ST_SCAN;
				end
			end
			fpa_pkg::ST_SCAN: begin
				if (ch_flags[NUM_BLOCKS].valid) begin
					state_d = fpa_pkg::ST_DONE;
				end
			end
			fpa_pkg::ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					finish  = 1'b1;
					state_d = fpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpa_pkg::ST_IDLE;
			end
		endcase
	end

	// Picks and the sum from the last cell stay held until the next scan, but
	// its flags are not. The result is formed while the output register drains.
	always_comb begin
		lf         = ch_flags[NUM_BLOCKS];
		res_placed = place_q && (lf.found_a || lf.found_b);
		res_pick   = lf.found_a ? ch_pick_a[NUM_BLOCKS] : ch_pick_b[NUM_BLOCKS];
		res_pval   = lf.found_a ? ch_val_a[NUM_BLOCKS] : ch_val_b[NUM_BLOCKS];
		res_rest   = res_pval - req_q;
		if (place_q) begin
			res_left  = res_placed ? fpa_pkg::LEFT_W'(res_rest) : '0;
			res_block = res_placed ? fpa_pkg::BIDX_W'(res_pick) : '0;
		end else begin
			res_left  = load_ok_q ? fpa_pkg::LEFT_W'(req_q) : '0;
			res_block = bidx_q;
		end
		res_sum = res_placed ? ch_sum[NUM_BLOCKS] - fpa_pkg::SUM_W'(req_q)
		                     : ch_sum[NUM_BLOCKS];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			place_q    <= (s_tuser[0] == fpa_pkg::ACT_PLACE);
			req_q      <= SIZE_BITS'(s_tdata[19:4]);
			load_ok_q  <= 32'(s_tdata[3:0]) < NUM_BLOCKS;
			load_idx_q <= IDX_W'(s_tdata[3:0]);
			bidx_q     <= s_tdata[3:0];
			cnt_q      <= count_use;
			start_q    <= (CNT_W'(cursor_q) < count_use) ? cursor_q : '0;
		end
		if (finish) begin
			commit_pick_q <= res_pick;
			m_data_q      <= {res_sum, res_left, res_block};
			m_placed_q    <= res_placed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q  <= 1'b0;
			commit_q  <= 1'b0;
			cursor_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			launch_q <= accept;
			commit_q <= finish && res_placed;
			if (finish) begin
				m_valid_q <= 1'b1;
				if (!place_q && load_ok_q) begin
					cursor_q <= '0;
				end else if (res_placed && (mode_q == fpa_pkg::MODE_NEXT)) begin
					cursor_q <= res_pick;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign ch_flags[0]  = '{valid: launch_q, found_a: 1'b0, found_b: 1'b0};
	assign ch_sum[0]    = '0;
	assign ch_pick_a[0] = '0;
	assign ch_val_a[0]  = '0;
	assign ch_pick_b[0] = '0;
	assign ch_val_b[0]  = '0;

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		fpa_cell #(
			.CELL_INDEX (i),
			.SIZE_BITS  (SIZE_BITS),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd_place    (place_q),
			.cmd_mode     (mode_q),
			.cmd_req      (req_q),
			.cmd_load_ok  (load_ok_q),
			.cmd_load_idx (load_idx_q),
			.cmd_count    (cnt_q),
			.cmd_start    (start_q),
			.commit_valid (commit_q),
			.commit_pick  (commit_pick_q),
			.in_flags     (ch_flags[i]),
			.in_sum       (ch_sum[i]),
			.in_pick_a    (ch_pick_a[i]),
			.in_val_a     (ch_val_a[i]),
			.in_pick_b    (ch_pick_b[i]),
			.in_val_b     (ch_val_b[i]),
			.out_flags    (ch_flags[i+1]),
			.out_sum      (ch_sum[i+1]),
			.out_pick_a   (ch_pick_a[i+1]),
			.out_val_a    (ch_val_a[i+1]),
			.out_pick_b   (ch_pick_b[i+1]),
			.out_val_b    (ch_val_b[i+1])
		);
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_placed_q;

endmodule

`default_nettype wire

>>> sim/fit_placement_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_placement_allocator_tb: self-checking bench for the placement allocator
// Items are queued by the stimulus block and streamed by a clocked driver. A
// behavioral table of block capacities predicts every result beat, and the
// monitor compares each beat field by field in order. The run covers all
// four fit policies, many block counts and random stalls on both streams.
// ----------------------------------------------------------------------------

module fit_placement_allocator_tb;

	localparam int TABLE_SIZE  = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = TABLE_SIZE + 8;

	typedef struct packed {
		logic                       action;
		logic [fpa_pkg::BIDX_W-1:0] index;
		logic [fpa_pkg::AMT_W-1:0]  amount;
	} alloc_req_t;

	typedef struct packed {
		logic                       placed;
		logic [fpa_pkg::BIDX_W-1:0] block;
		logic [fpa_pkg::LEFT_W-1:0] left;
		logic [fpa_pkg::SUM_W-1:0]  total;
	} alloc_res_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = fpa_pkg::REG_MODE;
	logic [4:0]        cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata   = '0;   // block_index[3:0], amount[19:4], zero pad
	logic [0:0]        s_tuser   = '0;   // action[0]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [39:0]       m_tdata;          // chosen_block[3:0], block_left[19:4],
	                                     // free_total[39:20]
	logic [0:0]        m_tuser;          // placed[0]

	// Behavioral copy of the allocator state.
	logic [fpa_pkg::AMT_W-1:0]   free_cap [TABLE_SIZE];
	logic [fpa_pkg::BIDX_W-1:0]  next_fit_cursor = '0;
	fpa_pkg::mode_t              mode_reg        = fpa_pkg::MODE_FIRST;
	logic [fpa_pkg::COUNT_W-1:0] count_reg       = 5'd16;

	alloc_req_t pending_reqs[$];
	alloc_res_t expected_results[$];
	alloc_req_t req_on_bus;
	alloc_res_t beat_seen;
	alloc_res_t beat_want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors        = 0;
	int cycles        = 0;

	fit_placement_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Applies one item to the capacity table and returns the result it yields.
	function automatic alloc_res_t predict_allocation(alloc_req_t r);
		int         in_use;
		int         pick;
		int         j;
		int         i;
		logic [20:0] sum;
		alloc_res_t res;
		in_use = (count_reg == 0) ? 1
		       : ((int'(count_reg) > TABLE_SIZE) ? TABLE_SIZE : int'(count_reg));
		res = '0;
		if (r.action == fpa_pkg::ACT_LOAD) begin
			free_cap[r.index] = r.amount;
			next_fit_cursor = '0;
			res.block = r.index;
			res.left = r.amount;
		end else begin
			pick = -1;
			if (mode_reg == fpa_pkg::MODE_NEXT) begin
				// A cursor outside the blocks in use restarts the scan at block zero.
				j = (int'(next_fit_cursor) < in_use) ? int'(next_fit_cursor) : 0;
				for (i = 0; i < in_use; i++) begin
					if (pick < 0 && free_cap[j] >= r.amount)
						pick = j;
					j = (j + 1 == in_use) ? 0 : j + 1;
				end
			end else begin
				for (i = 0; i < in_use; i++) begin
					if (free_cap[i] >= r.amount) begin
						if (pick < 0)
							pick = i;
						else if (mode_reg == fpa_pkg::MODE_BEST &&
						         free_cap[i] < free_cap[pick])
							pick = i;
						else if (mode_reg == fpa_pkg::MODE_WORST &&
						         free_cap[i] > free_cap[pick])
							pick = i;
					end
				end
			end
			if (pick >= 0) begin
				free_cap[pick] = free_cap[pick] - r.amount;
				if (mode_reg == fpa_pkg::MODE_NEXT)
					next_fit_cursor = fpa_pkg::BIDX_W'(pick);
				res.placed = 1'b1;
				res.block = fpa_pkg::BIDX_W'(pick);
				res.left = free_cap[pick];
			end
		end
		sum = '0;
		for (i = 0; i < in_use; i++)
			sum = sum + 21'(free_cap[i]);
		res.total = sum[fpa_pkg::SUM_W-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Driver: a new beat may be offered when the bus is free or was just taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_allocation(req_on_bus));
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, req_on_bus.amount, req_on_bus.index};
					s_tuser  <= req_on_bus.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beat_seen = {m_tuser[0], m_tdata[3:0], m_tdata[19:4], m_tdata[39:20]};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, beat_seen);
					errors++;
				end else begin
					beat_want = expected_results.pop_front();
					check_field("placed", 32'(beat_want.placed), 32'(beat_seen.placed));
					check_field("chosen_block", 32'(beat_want.block), 32'(beat_seen.block));
					check_field("block_left", 32'(beat_want.left), 32'(beat_seen.left));
					check_field("free_total", 32'(beat_want.total), 32'(beat_seen.total));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic index, logic [4:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == fpa_pkg::REG_MODE)
			mode_reg = fpa_pkg::mode_t'(value[1:0]);
		else
			count_reg = value;
	endtask

	task automatic add_req(logic action, logic [3:0] index, logic [15:0] amount);
		alloc_req_t r;
		r.action = action;
		r.index = index;
		r.amount = amount;
		pending_reqs.push_back(r);
	endtask

	// Holds off until every queued item has been answered, then lets the late
	// capacity update of a placed request finish.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic alloc_req_t random_req();
		alloc_req_t r;
		int         pick;
		r.index = fpa_pkg::BIDX_W'($urandom_range(15));
		pick = $urandom_range(99);
		if ($urandom_range(99) < 35) begin
			r.action = fpa_pkg::ACT_LOAD;
			if (pick < 8)
				r.amount = '0;
			else if (pick < 16)
				r.amount = 16'hFFFF;
			else if (pick < 60)
				r.amount = fpa_pkg::AMT_W'($urandom_range(4095));
			else
				r.amount = fpa_pkg::AMT_W'($urandom);
		end else begin
			r.action = fpa_pkg::ACT_PLACE;
			if (pick < 5)
				r.amount = '0;
			else if (pick < 65)
				r.amount = fpa_pkg::AMT_W'($urandom_range(1, 1023));
			else if (pick < 85)
				r.amount = fpa_pkg::AMT_W'($urandom_range(16383));
			else
				r.amount = fpa_pkg::AMT_W'($urandom);
		end
		return r;
	endfunction

	logic [4:0] phase_counts [10] = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1,
	                                 5'd16, 5'd9, 5'd17, 5'd3, 5'd16};

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++)
			free_cap[i] = '0;
		send_idle_pct = 6;
		recv_idle_pct = 58;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: first fit on extreme capacities.
		write_reg(fpa_pkg::REG_MODE, 5'(fpa_pkg::MODE_FIRST));
		write_reg(fpa_pkg::REG_COUNT, 5'd16);
		add_req(fpa_pkg::ACT_LOAD, 4'd0, 16'hFFFF);
		add_req(fpa_pkg::ACT_LOAD, 4'd15, 16'h0000);
		add_req(fpa_pkg::ACT_LOAD, 4'd5, 16'hAAAA);
		add_req(fpa_pkg::ACT_LOAD, 4'd10, 16'h5555);
		add_req(fpa_pkg::ACT_LOAD, 4'd3, 16'd100);
		add_req(fpa_pkg::ACT_PLACE, 4'd15, 16'd0);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'hFFFF);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'hFFFF);
		add_req(fpa_pkg::ACT_PLACE, 4'd7, 16'd200);
		drain();

		// Next fit walks the cursor forward, then a smaller count leaves it stale.
		write_reg(fpa_pkg::REG_MODE, 5'(fpa_pkg::MODE_NEXT));
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd30000);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd20000);
		drain();
		write_reg(fpa_pkg::REG_COUNT, 5'd4);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd50);
		drain();

		// A zero count behaves as one block; loads outside it are kept aside.
		write_reg(fpa_pkg::REG_COUNT, 5'd0);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd0);
		add_req(fpa_pkg::ACT_LOAD, 4'd7, 16'd500);
		drain();

		// An oversize count saturates to the whole table.
		write_reg(fpa_pkg::REG_COUNT, 5'd31);
		write_reg(fpa_pkg::REG_MODE, 5'(fpa_pkg::MODE_BEST));
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd90);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd1);
		drain();
		write_reg(fpa_pkg::REG_MODE, 5'(fpa_pkg::MODE_WORST));
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd90);
		add_req(fpa_pkg::ACT_PLACE, 4'd0, 16'd1);
		drain();

		// Random part: every phase changes the policy and the block count.
		for (int p = 0; p < 10; p++) begin
			if (p < 4) begin
				send_idle_pct = 6;
				recv_idle_pct = 58;
			end else if (p < 7) begin
				send_idle_pct = 58;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(fpa_pkg::REG_MODE, 5'(p % 4));
			write_reg(fpa_pkg::REG_COUNT, phase_counts[p]);
			for (int k = 0; k < 130; k++)
				pending_reqs.push_back(random_req());
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
